// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the timer bank RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/stb_pkg.sv =====
// ---------------------------------------------------------------------------
// Timer bank package
// Sizes, request codes and the command and status types of the timer bank.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int ID_WIDTH    = 4;
    localparam int REQ_WIDTH   = 2;
    localparam int PERIOD_WIDTH = 32;

    localparam logic [REQ_WIDTH-1:0] REQ_TICK     = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_START    = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_STOP     = 2'd2;
    localparam logic [REQ_WIDTH-1:0] REQ_DISPATCH = 2'd3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [TIMER_COUNT-1:0] mask_t;

    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
        logic emit;
    } stb_cmd_t;

    typedef struct packed {
        logic fired_any;
        logic last_one;
    } stb_stat_t;

endpackage

`default_nettype wire

// ===== rtl/stb_datapath.sv =====
// ---------------------------------------------------------------------------
// Timer bank datapath
// Holds the timer counters and flags, updates them on commands, and keeps
// the output register for fired timer ids.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stb_datapath
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire stb_pkg::stb_cmd_t                    cmd,
    input  wire logic [stb_pkg::ID_WIDTH-1:0]         timer_id,
    input  wire logic [stb_pkg::PERIOD_WIDTH-1:0]     period_ticks,
    input  wire logic                                 repeat_req,
    output stb_pkg::stb_stat_t                        stat,
    output logic [stb_pkg::ID_WIDTH-1:0]              fired_id,
    output logic                                      last_fired
);

    stb_pkg::count_t count_reg  [stb_pkg::TIMER_COUNT];
    stb_pkg::count_t count_next [stb_pkg::TIMER_COUNT];
    stb_pkg::count_t reload_reg  [stb_pkg::TIMER_COUNT];
    stb_pkg::count_t reload_next [stb_pkg::TIMER_COUNT];
    stb_pkg::mask_t  repeat_reg;
    stb_pkg::mask_t  repeat_next;
    stb_pkg::mask_t  running_reg;
    stb_pkg::mask_t  running_next;
    stb_pkg::mask_t  fired_reg;
    stb_pkg::mask_t  fired_next;

    logic [stb_pkg::ID_WIDTH-1:0] fired_id_reg;
    logic [stb_pkg::ID_WIDTH-1:0] fired_id_next;
    logic                         last_fired_reg;
    logic                         last_fired_next;

    logic [stb_pkg::ID_WIDTH-1:0] low_id;
    stb_pkg::mask_t               low_hot;
    stb_pkg::mask_t               remain_mask;

    always_comb
    begin
        low_id  = '0;
        low_hot = '0;
        for (int i = stb_pkg::TIMER_COUNT - 1; i >= 0; i--)
        begin
            if (fired_reg[i])
            begin
                low_id     = stb_pkg::ID_WIDTH'(i);
                low_hot    = '0;
                low_hot[i] = 1'b1;
            end
        end
        remain_mask = fired_reg & ~low_hot;
    end

    assign stat.fired_any = |fired_reg;
    assign stat.last_one  = ~|remain_mask;

    always_comb
    begin
        stb_pkg::count_t dec_val;
        dec_val      = '0;
        count_next   = count_reg;
        reload_next  = reload_reg;
        repeat_next  = repeat_reg;
        running_next = running_reg;
        fired_next   = fired_reg;
        for (int i = 0; i < stb_pkg::TIMER_COUNT; i++)
        begin
            dec_val = count_reg[i] - stb_pkg::COUNT_WIDTH'(1);
            if (cmd.start && timer_id == stb_pkg::ID_WIDTH'(i))
            begin
                count_next[i]   = period_ticks[stb_pkg::COUNT_WIDTH-1:0];
                reload_next[i]  = period_ticks[stb_pkg::COUNT_WIDTH-1:0];
                repeat_next[i]  = repeat_req;
                running_next[i] = 1'b1;
                fired_next[i]   = 1'b0;
            end
            else if (cmd.stop && timer_id == stb_pkg::ID_WIDTH'(i))
            begin
                running_next[i] = 1'b0;
            end
            else if (cmd.tick && running_reg[i] && count_reg[i] != '0)
            begin
                count_next[i] = dec_val;
                if (dec_val == '0)
                begin
                    fired_next[i] = 1'b1;
                    if (repeat_reg[i])
                    begin
                        count_next[i] = reload_reg[i];
                    end
                    else
                    begin
                        running_next[i] = 1'b0;
                    end
                end
            end
        end
        if (cmd.emit)
        begin
            fired_next = remain_mask;
        end
    end

    always_comb
    begin
        fired_id_next   = fired_id_reg;
        last_fired_next = last_fired_reg;
        if (cmd.emit)
        begin
            fired_id_next   = low_id;
            last_fired_next = stat.last_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '{default: '0};
            reload_reg     <= '{default: '0};
            repeat_reg     <= '0;
            running_reg    <= '0;
            fired_reg      <= '0;
            fired_id_reg   <= '0;
            last_fired_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            reload_reg     <= reload_next;
            repeat_reg     <= repeat_next;
            running_reg    <= running_next;
            fired_reg      <= fired_next;
            fired_id_reg   <= fired_id_next;
            last_fired_reg <= last_fired_next;
        end
    end

    assign fired_id   = fired_id_reg;
    assign last_fired = last_fired_reg;

    `ASSERT_NEXT(a_emit_clears_one, clk, rst_n, cmd.emit,
        $countones(fired_reg) + 1 == $countones($past(fired_reg)))
    `ASSERT_SAME(a_one_command, clk, rst_n, 1'b1,
        $onehot0({cmd.tick, cmd.start, cmd.stop, cmd.emit}))

endmodule

`default_nettype wire

// ===== rtl/stb_ctrl.sv =====
// ---------------------------------------------------------------------------
// Timer bank controller
// Decodes accepted requests into datapath commands and sequences the
// dispatch of fired timer ids through the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stb_ctrl
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [stb_pkg::REQ_WIDTH-1:0]     req_type,
    input  wire logic                              out_stall,
    input  wire stb_pkg::stb_stat_t                stat,
    output logic                                   in_stall,
    output logic                                   out_valid,
    output stb_pkg::stb_cmd_t                      cmd
);

    localparam logic ST_IDLE     = 1'b0;
    localparam logic ST_DISPATCH = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic in_accept;
    logic out_free;

    assign in_stall  = (state_reg == ST_DISPATCH);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign cmd.tick  = in_accept && (req_type == stb_pkg::REQ_TICK);
    assign cmd.start = in_accept && (req_type == stb_pkg::REQ_START);
    assign cmd.stop  = in_accept && (req_type == stb_pkg::REQ_STOP);
    assign cmd.emit  = (state_reg == ST_DISPATCH) && out_free && stat.fired_any;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && req_type == stb_pkg::REQ_DISPATCH && stat.fired_any)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (cmd.emit && stat.last_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_SAME(a_dispatch_has_work, clk, rst_n, state_reg == ST_DISPATCH,
        stat.fired_any)
    `ASSERT_NEXT(a_dispatch_entered, clk, rst_n,
        in_accept && req_type == stb_pkg::REQ_DISPATCH && stat.fired_any,
        state_reg == ST_DISPATCH)
    `ASSERT_NEXT(a_emit_shows_result, clk, rst_n, cmd.emit, out_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/software_timer_bank.sv =====
// Tick, start and stop requests are accepted back to back.
// A dispatch with nothing fired is accepted and leaves the bank idle; one that finds
// N fired timers stalls the input until the last of the N ids is emitted, receiver stalls included.
// The first id passes the state register, then the output register; one id per cycle
// follows unless the receiver stalls, via the single output register and lowest-index fired search.
// Reset is asynchronous: all timers go idle and all fired marks clear at once.
// ---------------------------------------------------------------------------
// Software timer bank
// Sixteen countdown timers with one-shot or periodic reload and an in-order
// dispatch of the ids of fired timers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [stb_pkg::REQ_WIDTH-1:0]        req_type,
    input  wire logic [stb_pkg::ID_WIDTH-1:0]         timer_id,
    input  wire logic [stb_pkg::PERIOD_WIDTH-1:0]     period_ticks,
    input  wire logic                                 repeat_req,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [stb_pkg::ID_WIDTH-1:0]              fired_id,
    output logic                                      last_fired
);

    stb_pkg::stb_cmd_t  cmd;
    stb_pkg::stb_stat_t stat;

    stb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    stb_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .timer_id     (timer_id),
        .period_ticks (period_ticks),
        .repeat_req   (repeat_req),
        .stat         (stat),
        .fired_id     (fired_id),
        .last_fired   (last_fired)
    );

endmodule

`default_nettype wire
